>>> design/dsa_pkg.sv
// Package for the deadline slot allocator: request and response payloads,
// controller states, and the command/status bundles between controller and datapath.
// No dependencies.
package dsa_pkg;

  localparam int MAX_SLOTS_DEF = 4096;
  localparam int DL_W          = 13;
  localparam int RW_W          = 20;
  localparam int SUM_W         = 32;
  localparam logic [DL_W-1:0] NUM_SLOTS_RST = 13'd4096;

  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [RW_W-1:0] reward;
  } dsa_req_t;

  typedef struct packed {
    logic             accepted;
    logic [DL_W-1:0]  slot;
    logic [SUM_W-1:0] total_reward;
  } dsa_resp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_Q,
    S_FIRST,
    S_CHASE,
    S_LINK,
    S_DONE
  } dsa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;   // write entry at sweep counter with its own index
    logic take_req;   // capture clamped deadline and reward
    logic rd_q;       // read entry at query index
    logic rd_next;    // read entry at last read value, hold it as current link
    logic wr_q;       // write last read value to query entry
    logic start_link; // job accepted: add reward, query the slot below the root
    logic reject;     // job rejected
    logic wr_link;    // write root of the slot below into the taken slot
    logic load_out;   // move result into the output register
  } dsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;   // sweep counter at last entry
    logic hit;        // read value equals current link: root found
    logic root_zero;  // read value is slot zero
    logic out_busy;   // output register holds a result that is not being taken
  } dsa_stat_t;

endpackage

>>> design/dsa_ctrl.sv
// Controller of the deadline slot allocator: sequences clear sweep, lookups and links.
// Depends on dsa_pkg.
module dsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  dsa_pkg::dsa_stat_t stat,
  output dsa_pkg::dsa_cmd_t  cmd
);
  import dsa_pkg::*;

  dsa_state_t state, state_next;
  logic       second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    second_next = second;
    unique case (state)
      S_CLEAR: if (stat.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) begin
          state_next  = S_RD_Q;
          second_next = 1'b0;
        end
      end
      S_RD_Q:  state_next = S_FIRST;
      S_FIRST: state_next = S_CHASE;
      S_CHASE: begin
        if (stat.hit) begin
          if (second) begin
            state_next = S_LINK;
          end else if (stat.root_zero) begin
            state_next = S_DONE;
          end else begin
            state_next  = S_RD_Q;
            second_next = 1'b1;
          end
        end
      end
      S_LINK:  state_next = S_DONE;
      S_DONE:  if (!stat.out_busy) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.take_req = req_valid;
      end
      S_RD_Q:  cmd.rd_q = 1'b1;
      S_FIRST: cmd.rd_next = 1'b1;
      S_CHASE: begin
        if (stat.hit) begin
          cmd.wr_q = 1'b1;
          if (!second) begin
            cmd.start_link = !stat.root_zero;
            cmd.reject     = stat.root_zero;
          end
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_LINK:  cmd.wr_link = 1'b1;
      S_DONE:  cmd.load_out = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/dsa_datapath.sv
// Datapath of the deadline slot allocator: link table memory, query and root
// registers, saturating reward sum and output register. Depends on dsa_pkg.
module dsa_datapath #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dsa_pkg::DL_W-1:0]   cfg_wdata,
  input  dsa_pkg::dsa_req_t          req,
  input  logic                       resp_ready,
  output logic                       resp_valid,
  output dsa_pkg::dsa_resp_t         resp,
  input  dsa_pkg::dsa_cmd_t          cmd,
  output dsa_pkg::dsa_stat_t         stat
);
  import dsa_pkg::*;

  localparam int DEPTH = MAX_SLOTS + 1;
  localparam int IW    = $clog2(DEPTH);

  logic [IW-1:0]    link_mem [DEPTH];
  logic [IW-1:0]    rdata;
  logic [IW-1:0]    addr;
  logic [IW-1:0]    wdata;
  logic             mem_we;
  logic             mem_rd;

  logic [IW-1:0]    clr_cnt;
  logic [IW-1:0]    query;
  logic [IW-1:0]    cur;
  logic [IW-1:0]    root;
  logic [RW_W-1:0]  reward;
  logic             accepted;
  logic [SUM_W-1:0] reward_sum;
  logic [DL_W-1:0]  num_slots;
  logic             out_full;
  dsa_resp_t        resp_q;

  logic [31:0]      limit;
  logic [31:0]      dl_clamped;
  logic [SUM_W:0]   sum_wide;

  // clamp deadline to the slots in use, and those to the table size
  always_comb begin
    limit      = (32'(num_slots) > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS) : 32'(num_slots);
    dl_clamped = (32'(req.deadline) > limit) ? limit : 32'(req.deadline);
    sum_wide   = {1'b0, reward_sum} + (SUM_W+1)'(reward);
  end

  // memory port select
  always_comb begin
    addr   = query;
    wdata  = rdata;
    mem_we = 1'b0;
    mem_rd = 1'b0;
    if (cmd.clr_step) begin
      addr   = clr_cnt;
      wdata  = clr_cnt;
      mem_we = 1'b1;
    end else if (cmd.rd_q) begin
      addr   = query;
      mem_rd = 1'b1;
    end else if (cmd.rd_next) begin
      addr   = rdata;
      mem_rd = 1'b1;
    end else if (cmd.wr_q) begin
      addr   = query;
      wdata  = rdata;
      mem_we = 1'b1;
    end else if (cmd.wr_link) begin
      addr   = root;
      wdata  = cur;
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[addr] <= wdata;
    if (mem_rd) rdata <= link_mem[addr];
  end

  // job registers
  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      query  <= IW'(dl_clamped);
      reward <= req.reward;
    end
    if (cmd.rd_next || cmd.wr_q) cur <= rdata;
    if (cmd.start_link) begin
      root  <= rdata;
      query <= rdata - IW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      reward_sum <= '0;
      num_slots  <= NUM_SLOTS_RST;
      out_full   <= 1'b0;
      accepted   <= 1'b0;
    end else begin
      if (cmd.clr_step && clr_cnt != IW'(MAX_SLOTS)) clr_cnt <= clr_cnt + IW'(1);
      if (cfg_we) num_slots <= cfg_wdata;
      if (cmd.start_link) begin
        accepted   <= 1'b1;
        reward_sum <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end
      if (cmd.reject) accepted <= 1'b0;
      if (cmd.load_out) out_full <= 1'b1;
      else if (resp_ready) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      resp_q.accepted     <= accepted;
      resp_q.slot         <= accepted ? DL_W'(root) : '0;
      resp_q.total_reward <= reward_sum;
    end
  end

  assign resp_valid     = out_full;
  assign resp           = resp_q;
  assign stat.clr_last  = (clr_cnt == IW'(MAX_SLOTS));
  assign stat.hit       = (rdata == cur);
  assign stat.root_zero = (rdata == '0);
  assign stat.out_busy  = out_full && !resp_ready;

endmodule

>>> design/deadline_slot_allocator.sv
// Top level of the deadline slot allocator: controller plus datapath.
// Depends on dsa_pkg, dsa_ctrl and dsa_datapath.
//
//  channel   signals                     direction  carries
//  req       req_valid/req_ready, req    in         deadline, reward of one job
//  resp      resp_valid/resp_ready, resp out        accepted, slot, total_reward
//  cfg       cfg_we, cfg_wdata           in         num_slots, no read-back
//
// After reset the link table is swept to identity, one entry a cycle; no
// request is taken until the sweep ends (cfg writes still land).
// One request is handled at a time. Each root lookup reads the query entry,
// then follows one link at a time; the single-port link table memory sets this.
// A rejected job needs one lookup and an accepted one two, both over chains
// that path compression keeps short.
// A finished result waits in the output register; a new request is taken
// meanwhile, and only the hand-over of its own result waits on resp_ready.
module deadline_slot_allocator #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  dsa_pkg::dsa_req_t        req,
  output logic                     resp_valid,
  input  logic                     resp_ready,
  output dsa_pkg::dsa_resp_t       resp,
  input  logic                     cfg_we,
  input  logic [dsa_pkg::DL_W-1:0] cfg_wdata
);
  import dsa_pkg::*;

  dsa_cmd_t  cmd;
  dsa_stat_t stat;

  // sequence each job: lookup, compress, link
  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold the link table, running total and result register
  dsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .resp_ready (resp_ready),
    .resp_valid (resp_valid),
    .resp       (resp),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
